// ===== rtl/tsme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_pkg
// Types and codes shared by the two-set membership engine.
// ----------------------------------------------------------------------------
package tsme_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 3'd0,
        OP_CONTAINS = 3'd1,
        OP_UNION    = 3'd2,
        OP_INTER    = 3'd3,
        OP_DIFF     = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FULL    = 3'd2,
        ST_FOUND   = 3'd3,
        ST_ABSENT  = 3'd4,
        ST_MEMBER  = 3'd5,
        ST_EMPTY   = 3'd6,
        ST_CLEARED = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_GO,
        S_SCAN_WAIT,
        S_OUT_RD,
        S_OUT_WAIT,
        S_PUSH,
        S_FINAL
    } state_t;

    // status of the shared compare unit
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } scan_res_t;

endpackage

// ===== rtl/tsme_op_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_op_if
// Request channel: one operation item with its target set and element.
// ----------------------------------------------------------------------------
interface tsme_op_if
    import tsme_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic                     target_set;
    logic signed [DATA_W-1:0] element;

    modport source (output valid, output operation, output target_set, output element,
                    input ready);
    modport sink   (input valid, input operation, input target_set, input element,
                    output ready);
endinterface

// ===== rtl/tsme_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_res_if
// Result channel: one result item with value, status and last flag.
// ----------------------------------------------------------------------------
interface tsme_res_if
    import tsme_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] item_value;
    logic [STATUS_W-1:0]      status;
    logic                     last_item;

    modport source (output valid, output item_value, output status, output last_item,
                    input ready);
    modport sink   (input valid, input item_value, input status, input last_item,
                    output ready);
endinterface

// ===== rtl/tsme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/tsme_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_scan
// Shared compare unit: walks the first count entries of a set store, one
// read issued and one compare made per cycle, and stops on the first match.
// ----------------------------------------------------------------------------
module tsme_scan
    import tsme_pkg::*;
#(
    parameter int SET_CAPACITY = 32
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 start,
    input  logic [DATA_W-1:0]                                    key,
    input  logic [$clog2(SET_CAPACITY + 1)-1:0]                  count,
    input  logic [DATA_W-1:0]                                    rd_data,
    output logic                                                 rd_en,
    output logic [((SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1)-1:0] rd_addr,
    output scan_res_t                                            status
);

    localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);

    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             more;
    logic             hit;
    logic             miss;

    always_comb
    begin
        more    = issue_reg < count;
        rd_en   = busy_reg && more;
        rd_addr = issue_reg[IDX_W-1:0];
        // data of the read issued last cycle is on rd_data now
        hit     = busy_reg && pend_reg && (rd_data == key);
        miss    = busy_reg && !pend_reg && !more;

        busy_next  = busy_reg;
        pend_next  = rd_en;
        issue_next = issue_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            pend_next  = 1'b0;
            issue_next = '0;
        end
        else if (hit || miss)
        begin
            busy_next = 1'b0;
            pend_next = 1'b0;
        end
        else if (rd_en)
        begin
            issue_next = issue_reg + 1'b1;
        end

        status.busy = busy_reg;
        status.done = hit || miss;
        status.hit  = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            issue_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
            issue_reg <= issue_next;
        end
    end

endmodule

// ===== rtl/two_set_membership_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_set_membership_engine_unit
// Two bounded integer sets A and B with add, contains, clear and the set
// operations union, intersection and difference (A minus B).
//
// Usage: one request item on "op" (operation, target_set, element) gives one
// or more result items on "res", the final one flagged by last_item. Add,
// contains and clear give one item; a set operation gives its members in
// order (union: A, then B members not in A) or one empty-marked item.
// op.ready is high only while the engine is idle; one item is worked on at
// a time. All membership tests go through one shared compare unit that reads
// one stored entry per cycle and stops on the first match; an undefined
// operation code is accepted but gives no result item.
// Results leave through an output register; a stalled receiver holds the
// engine in place until the pending item is taken, no item is dropped.
// Reset empties both sets (counts go to zero); the store contents are not
// cleared and are never read past the count.
// ----------------------------------------------------------------------------
module two_set_membership_engine_unit
    import tsme_pkg::*;
#(
    parameter int SET_CAPACITY = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    tsme_op_if.sink  op,
    tsme_res_if.source res
);

    localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(SET_CAPACITY);

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic              tgt_reg, tgt_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              scan_sel_reg, scan_sel_next;
    logic              phase_reg, phase_next;
    logic [CNT_W-1:0]  outer_idx_reg, outer_idx_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [DATA_W-1:0] pend_value_reg, pend_value_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [CNT_W-1:0]  outer_cnt;
    logic              outer_more;
    logic              outer_rd;
    logic [CNT_W-1:0]  scan_cnt;
    logic [CNT_W-1:0]  tgt_cnt;
    logic              set_full;
    logic              qualify;
    logic              union_first;
    logic              add_commit;

    logic              scan_start;
    logic              scan_rd_en;
    logic [IDX_W-1:0]  scan_rd_addr;
    scan_res_t         scan_res;
    logic [DATA_W-1:0] scan_q;
    logic [DATA_W-1:0] outer_q;

    logic              rd_en_a, rd_en_b;
    logic [IDX_W-1:0]  rd_addr_a, rd_addr_b;
    logic [DATA_W-1:0] q_a, q_b;
    logic              wr_en_a, wr_en_b;
    logic [IDX_W-1:0]  wr_addr;

    // ------------------------------------------------------------------
    // shared status terms
    // ------------------------------------------------------------------
    always_comb
    begin
        op.ready    = (state_reg == S_IDLE);
        accept      = op.valid && op.ready;
        out_free    = !out_valid_reg || res.ready;
        outer_cnt   = phase_reg ? cnt_b_reg : cnt_a_reg;
        outer_more  = outer_idx_reg < outer_cnt;
        outer_rd    = (state_reg == S_OUT_RD) && outer_more;
        scan_cnt    = scan_sel_reg ? cnt_b_reg : cnt_a_reg;
        tgt_cnt     = tgt_reg ? cnt_b_reg : cnt_a_reg;
        set_full    = (tgt_cnt == CAP);
        scan_q      = scan_sel_reg ? q_b : q_a;
        outer_q     = phase_reg ? q_b : q_a;
        union_first = (op_reg == OP_UNION) && !phase_reg;
        qualify     = ((op_reg == OP_INTER) && scan_res.hit) ||
                      (((op_reg == OP_DIFF) || (op_reg == OP_UNION)) && !scan_res.hit);
        scan_start  = (state_reg == S_SCAN_GO);
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op.operation) inside
                        OP_ADD, OP_CONTAINS:     state_next = S_SCAN_GO;
                        OP_UNION, OP_INTER, OP_DIFF: state_next = S_OUT_RD;
                        OP_CLEAR:                state_next = S_FINAL;
                        default:                 state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN_GO:
            begin
                state_next = S_SCAN_WAIT;
            end
            S_SCAN_WAIT:
            begin
                if (scan_res.done)
                begin
                    if ((op_reg == OP_ADD) || (op_reg == OP_CONTAINS))
                    begin
                        state_next = S_FINAL;
                    end
                    else if (qualify)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_OUT_RD:
            begin
                if (outer_more)
                begin
                    state_next = S_OUT_WAIT;
                end
                else if (!union_first)
                begin
                    state_next = S_FINAL;
                end
            end
            S_OUT_WAIT:
            begin
                state_next = union_first ? S_PUSH : S_SCAN_GO;
            end
            S_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = S_OUT_RD;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and output controls
    // ------------------------------------------------------------------
    always_comb
    begin
        op_next         = op_reg;
        tgt_next        = tgt_reg;
        key_next        = key_reg;
        scan_sel_next   = scan_sel_reg;
        phase_next      = phase_reg;
        outer_idx_next  = outer_idx_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        res_status_next = res_status_reg;
        out_load        = 1'b0;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        add_commit      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op.operation;
                    tgt_next        = op.target_set;
                    key_next        = op.element;
                    phase_next      = 1'b0;
                    outer_idx_next  = '0;
                    pend_valid_next = 1'b0;
                    pend_value_next = '0;
                    // set ops walk A first; inter and diff look each up in B
                    scan_sel_next   = op.target_set;
                    case (op.operation) inside
                        OP_UNION, OP_INTER, OP_DIFF: scan_sel_next = 1'b1;
                        OP_CLEAR:
                        begin
                            res_status_next = ST_CLEARED;
                            if (op.target_set)
                            begin
                                cnt_b_next = '0;
                            end
                            else
                            begin
                                cnt_a_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN_GO:
            begin
            end
            S_SCAN_WAIT:
            begin
                if (scan_res.done)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        pend_value_next = key_reg;
                        if (scan_res.hit)
                        begin
                            res_status_next = ST_PRESENT;
                        end
                        else if (set_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            add_commit      = 1'b1;
                            res_status_next = ST_ADDED;
                            if (tgt_reg)
                            begin
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            else
                            begin
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                        end
                    end
                    else if (op_reg == OP_CONTAINS)
                    begin
                        pend_value_next = key_reg;
                        res_status_next = scan_res.hit ? ST_FOUND : ST_ABSENT;
                    end
                    else if (!qualify)
                    begin
                        outer_idx_next = outer_idx_reg + 1'b1;
                    end
                end
            end
            S_OUT_RD:
            begin
                if (!outer_more)
                begin
                    if (union_first)
                    begin
                        // second pass: B members, looked up in A
                        phase_next     = 1'b1;
                        outer_idx_next = '0;
                        scan_sel_next  = 1'b0;
                    end
                    else
                    begin
                        res_status_next = pend_valid_reg ? ST_MEMBER : ST_EMPTY;
                    end
                end
            end
            S_OUT_WAIT:
            begin
                key_next = outer_q;
            end
            S_PUSH:
            begin
                // hold one member back so the final one can carry last_item
                if (!pend_valid_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_value_next = key_reg;
                    outer_idx_next  = outer_idx_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_status_next = ST_MEMBER;
                    out_last_next   = 1'b0;
                    pend_value_next = key_reg;
                    outer_idx_next  = outer_idx_reg + 1'b1;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // memory port steering
    // ------------------------------------------------------------------
    always_comb
    begin
        rd_en_a   = (scan_rd_en && !scan_sel_reg) || (outer_rd && !phase_reg);
        rd_en_b   = (scan_rd_en && scan_sel_reg) || (outer_rd && phase_reg);
        rd_addr_a = outer_rd ? outer_idx_reg[IDX_W-1:0] : scan_rd_addr;
        rd_addr_b = outer_rd ? outer_idx_reg[IDX_W-1:0] : scan_rd_addr;
        wr_en_a   = add_commit && !tgt_reg;
        wr_en_b   = add_commit && tgt_reg;
        wr_addr   = tgt_cnt[IDX_W-1:0];
    end

    tsme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_CAPACITY)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr),
        .wr_data (key_reg),
        .rd_en   (rd_en_a),
        .rd_addr (rd_addr_a),
        .rd_data (q_a)
    );

    tsme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_CAPACITY)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr),
        .wr_data (key_reg),
        .rd_en   (rd_en_b),
        .rd_addr (rd_addr_b),
        .rd_data (q_b)
    );

    tsme_scan #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .key     (key_reg),
        .count   (scan_cnt),
        .rd_data (scan_q),
        .rd_en   (scan_rd_en),
        .rd_addr (scan_rd_addr),
        .status  (scan_res)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        tgt_reg        <= tgt_next;
        key_reg        <= key_next;
        scan_sel_reg   <= scan_sel_next;
        phase_reg      <= phase_next;
        outer_idx_reg  <= outer_idx_next;
        pend_value_reg <= pend_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.item_value = out_value_reg;
    assign res.status     = out_status_reg;
    assign res.last_item  = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_idle_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        op.ready |-> !scan_res.busy)
        else $error("compare unit busy while engine is idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CAP) && (cnt_b_reg <= CAP))
        else $error("set count beyond capacity");

    a_clear_a: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op.operation == OP_CLEAR) && !op.target_set |=> (cnt_a_reg == '0))
        else $error("clear of set A left members");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_last_next |=> (state_reg == S_IDLE))
        else $error("final result item loaded without returning to idle");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-set membership engine. A table of directed
// requests (empty sets, extreme values, duplicates, undefined codes, clears)
// runs first. Random request sequences follow: set building, fill to
// capacity, membership tests, set operations, clears and undefined codes.
// Every result item is checked against its table row or an in-bench model
// of both sets, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import tsme_pkg::*;

    localparam int SET_CAP        = 32;
    localparam int RANDOM_ITEMS   = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int MAX_REPORTS    = 10;

    localparam logic [OP_W-1:0] OP_UNDEF_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_7 = 3'd7;

    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SINGLE,
        CHK_SILENT
    } chk_kind_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
        logic              last_item;
    } outcome_t;

    typedef struct {
        logic [OP_W-1:0]   opc;
        logic              tgt;
        logic [DATA_W-1:0] elem;
        chk_kind_t         kind;
        status_t           exp_status;
        logic [DATA_W-1:0] exp_value;
    } table_row_t;

    logic clk;
    logic rst_n;

    tsme_op_if  op_if();
    tsme_res_if res_if();

    two_set_membership_engine_unit #(
        .SET_CAPACITY(SET_CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_if),
        .res   (res_if)
    );

    // model of both sets: index 0 is A, index 1 is B
    logic [DATA_W-1:0] members [2][SET_CAP];
    int unsigned       member_cnt [2];

    outcome_t   pending_results[$];
    outcome_t   predicted[$];
    table_row_t directed_rows[$];
    logic [DATA_W-1:0] value_pool[$];

    int  mismatches;
    int  unexpected;
    int  results_checked;
    int  items_sent;
    int  random_items;
    int  setops_sent;
    int  full_rejects;
    int  idle_cycles;
    int  ready_hold;
    int  ready_roll;
    bit  calm_mode;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // set model
    // ------------------------------------------------------------------
    function automatic bit holds_value(input int which, input logic [DATA_W-1:0] v);
        for (int i = 0; i < member_cnt[which]; i++)
        begin
            if (members[which][i] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_results(input logic [OP_W-1:0] opc, input logic tgt,
                                   input logic [DATA_W-1:0] v);
        outcome_t o;
        bit       in_b;
        int       which;
        which = tgt ? 1 : 0;
        predicted.delete();
        case (opc)
            OP_ADD:
            begin
                if (holds_value(which, v))
                    predicted.push_back('{v, ST_PRESENT, 1'b0});
                else if (member_cnt[which] >= SET_CAP)
                begin
                    predicted.push_back('{v, ST_FULL, 1'b0});
                    full_rejects++;
                end
                else
                begin
                    members[which][member_cnt[which]] = v;
                    member_cnt[which]++;
                    predicted.push_back('{v, ST_ADDED, 1'b0});
                end
            end
            OP_CONTAINS:
                predicted.push_back('{v, holds_value(which, v) ? ST_FOUND : ST_ABSENT, 1'b0});
            OP_UNION, OP_INTER, OP_DIFF:
            begin
                setops_sent++;
                for (int i = 0; i < member_cnt[0]; i++)
                begin
                    in_b = holds_value(1, members[0][i]);
                    if (opc == OP_UNION || (opc == OP_INTER && in_b) ||
                        (opc == OP_DIFF && !in_b))
                        predicted.push_back('{members[0][i], ST_MEMBER, 1'b0});
                end
                if (opc == OP_UNION)
                begin
                    for (int i = 0; i < member_cnt[1]; i++)
                    begin
                        if (!holds_value(0, members[1][i]))
                            predicted.push_back('{members[1][i], ST_MEMBER, 1'b0});
                    end
                end
                if (predicted.size() == 0)
                    predicted.push_back('{'0, ST_EMPTY, 1'b0});
            end
            OP_CLEAR:
            begin
                member_cnt[which] = 0;
                predicted.push_back('{'0, ST_CLEARED, 1'b0});
            end
            default:
                ;
        endcase
        // flag the final item of this request
        if (predicted.size() > 0)
        begin
            o = predicted.pop_back();
            o.last_item = 1'b1;
            predicted.push_back(o);
        end
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (calm_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_op(input logic [OP_W-1:0] opc, input logic tgt,
                           input logic [DATA_W-1:0] elem, input chk_kind_t kind,
                           input status_t exp_status, input logic [DATA_W-1:0] exp_value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            op_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_if.valid      <= 1'b1;
        op_if.operation  <= opc;
        op_if.target_set <= tgt;
        op_if.element    <= elem;
        // ready seen right after the edge is the value the edge used
        do
            @(posedge clk);
        while (!op_if.ready);
        predict_results(opc, tgt, elem);
        case (kind)
            CHK_PREDICT:
                foreach (predicted[i])
                    pending_results.push_back(predicted[i]);
            CHK_SINGLE:
                pending_results.push_back('{exp_value, exp_status, 1'b1});
            default:
                ;
        endcase
        items_sent++;
    endtask

    task automatic send_pred(input logic [OP_W-1:0] opc, input logic tgt,
                             input logic [DATA_W-1:0] elem);
        send_op(opc, tgt, elem, CHK_PREDICT, ST_ADDED, '0);
        if (opc <= OP_CLEAR)
            random_items++;
    endtask

    // hold requests until every pending result has been taken
    task automatic drain_results();
        op_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_row(input logic [OP_W-1:0] opc, input logic tgt,
                            input logic [DATA_W-1:0] elem, input chk_kind_t kind,
                            input status_t exp_status, input logic [DATA_W-1:0] exp_value);
        table_row_t row;
        row.opc        = opc;
        row.tgt        = tgt;
        row.elem       = elem;
        row.kind       = kind;
        row.exp_status = exp_status;
        row.exp_value  = exp_value;
        directed_rows.push_back(row);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        else if (r < 80)
            return $urandom;
        case ($urandom_range(0, 4))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return ALL_ONES;
            3: return 32'd1;
            default: return '0;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_setop();
        case ($urandom_range(0, 2))
            0: return OP_UNION;
            1: return OP_INTER;
            default: return OP_DIFF;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (calm_mode)
            res_if.ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65)
            begin
                res_if.ready <= 1'b1;
                ready_hold = $urandom_range(0, 4);
            end
            else if (ready_roll < 93)
            begin
                res_if.ready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end
            else
            begin
                res_if.ready <= 1'b0;
                ready_hold = $urandom_range(8, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t exp_item;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("unexpected result: value %h status %0d last %b",
                             res_if.item_value, res_if.status, res_if.last_item);
            end
            else
            begin
                exp_item = pending_results.pop_front();
                results_checked++;
                if (res_if.item_value !== exp_item.value || res_if.status !== exp_item.status
                    || res_if.last_item !== exp_item.last_item)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display("mismatch at result %0d: exp %h/%0d/%b got %h/%0d/%b",
                                 results_checked, exp_item.value, exp_item.status,
                                 exp_item.last_item, res_if.item_value, res_if.status,
                                 res_if.last_item);
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int scen;
        int tgt;
        int n;
        int tries;
        clk              = 1'b0;
        rst_n            = 1'b0;
        op_if.valid      = 1'b0;
        op_if.operation  = OP_ADD;
        op_if.target_set = 1'b0;
        op_if.element    = '0;
        res_if.ready     = 1'b0;
        calm_mode        = 1'b0;
        mismatches       = 0;
        unexpected       = 0;
        results_checked  = 0;
        items_sent       = 0;
        random_items     = 0;
        setops_sent      = 0;
        full_rejects     = 0;
        idle_cycles      = 0;
        ready_hold       = 0;
        member_cnt[0]    = 0;
        member_cnt[1]    = 0;

        for (int i = 0; i < 24; i++)
            value_pool.push_back($urandom);

        push_row(OP_CONTAINS, 1'b0, '0, CHK_SINGLE, ST_ABSENT, '0);
        push_row(OP_UNION, 1'b0, '0, CHK_SINGLE, ST_EMPTY, '0);
        push_row(OP_INTER, 1'b1, ALL_ONES, CHK_SINGLE, ST_EMPTY, '0);
        push_row(OP_DIFF, 1'b0, MOST_POS, CHK_SINGLE, ST_EMPTY, '0);
        push_row(OP_ADD, 1'b0, MOST_NEG, CHK_SINGLE, ST_ADDED, MOST_NEG);
        push_row(OP_ADD, 1'b0, MOST_POS, CHK_SINGLE, ST_ADDED, MOST_POS);
        push_row(OP_ADD, 1'b0, MOST_NEG, CHK_SINGLE, ST_PRESENT, MOST_NEG);
        push_row(OP_ADD, 1'b0, ALL_ONES, CHK_SINGLE, ST_ADDED, ALL_ONES);
        push_row(OP_ADD, 1'b0, '0, CHK_SINGLE, ST_ADDED, '0);
        push_row(OP_ADD, 1'b1, MOST_POS, CHK_SINGLE, ST_ADDED, MOST_POS);
        push_row(OP_ADD, 1'b1, 32'h5555_5555, CHK_SINGLE, ST_ADDED, 32'h5555_5555);
        push_row(OP_ADD, 1'b1, 32'haaaa_aaaa, CHK_SINGLE, ST_ADDED, 32'haaaa_aaaa);
        push_row(OP_CONTAINS, 1'b0, ALL_ONES, CHK_SINGLE, ST_FOUND, ALL_ONES);
        push_row(OP_CONTAINS, 1'b1, ALL_ONES, CHK_SINGLE, ST_ABSENT, ALL_ONES);
        push_row(OP_CONTAINS, 1'b1, 32'haaaa_aaaa, CHK_SINGLE, ST_FOUND, 32'haaaa_aaaa);
        push_row(OP_UNION, 1'b1, '0, CHK_PREDICT, ST_MEMBER, '0);
        push_row(OP_INTER, 1'b0, '0, CHK_PREDICT, ST_MEMBER, '0);
        push_row(OP_DIFF, 1'b1, '0, CHK_PREDICT, ST_MEMBER, '0);
        push_row(OP_UNDEF_6, 1'b1, ALL_ONES, CHK_SILENT, ST_ADDED, '0);
        push_row(OP_UNDEF_7, 1'b0, '0, CHK_SILENT, ST_ADDED, '0);
        push_row(OP_CLEAR, 1'b1, ALL_ONES, CHK_SINGLE, ST_CLEARED, '0);
        push_row(OP_CONTAINS, 1'b1, MOST_POS, CHK_SINGLE, ST_ABSENT, MOST_POS);
        push_row(OP_INTER, 1'b0, '0, CHK_SINGLE, ST_EMPTY, '0);
        push_row(OP_CLEAR, 1'b0, '0, CHK_SINGLE, ST_CLEARED, '0);
        push_row(OP_UNION, 1'b0, '0, CHK_SINGLE, ST_EMPTY, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_op(directed_rows[i].opc, directed_rows[i].tgt, directed_rows[i].elem,
                    directed_rows[i].kind, directed_rows[i].exp_status,
                    directed_rows[i].exp_value);
        drain_results();

        while (random_items < RANDOM_ITEMS)
        begin
            calm_mode = ($urandom_range(0, 9) == 0);
            tgt  = $urandom_range(0, 1);
            scen = $urandom_range(0, 99);
            if (scen < 40)
            begin
                // build up a set, probe it, combine
                n = $urandom_range(1, 6);
                repeat (n) send_pred(OP_ADD, tgt[0], pick_value());
                if ($urandom_range(0, 1))
                    send_pred(OP_CONTAINS, 1'($urandom_range(0, 1)), pick_value());
                send_pred(pick_setop(), 1'($urandom_range(0, 1)), $urandom);
            end
            else if (scen < 52)
            begin
                // fill one set to capacity, then push past it
                tries = 0;
                while (member_cnt[tgt] < SET_CAP && tries < 60)
                begin
                    send_pred(OP_ADD, tgt[0], ($urandom_range(0, 3) == 0) ? pick_value()
                                                                           : $urandom);
                    tries++;
                end
                send_pred(OP_ADD, tgt[0], $urandom);
                if (member_cnt[tgt] > 0)
                    send_pred(OP_ADD, tgt[0],
                              members[tgt][$urandom_range(0, member_cnt[tgt] - 1)]);
                send_pred(pick_setop(), tgt[0], $urandom);
                if ($urandom_range(0, 1))
                    send_pred(OP_CLEAR, tgt[0], $urandom);
            end
            else if (scen < 68)
            begin
                n = $urandom_range(2, 5);
                repeat (n) send_pred(OP_CONTAINS, 1'($urandom_range(0, 1)), pick_value());
            end
            else if (scen < 78)
            begin
                send_pred(OP_CLEAR, tgt[0], $urandom);
                send_pred(pick_setop(), 1'($urandom_range(0, 1)), $urandom);
            end
            else if (scen < 86)
                send_pred(OP_W'($urandom_range(OP_UNDEF_6, OP_UNDEF_7)), tgt[0], $urandom);
            else
                send_pred(OP_W'($urandom_range(0, 7)), tgt[0], $urandom);

            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        op_if.valid <= 1'b0;
        calm_mode = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d set operations, %0d full-set rejects),",
                 items_sent, setops_sent, full_rejects);
        $display("checked %0d result items, %0d mismatches, %0d unexpected.",
                 results_checked, mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tsme_pkg.sv
rtl/tsme_op_if.sv
rtl/tsme_res_if.sv
rtl/tsme_ram.sv
rtl/tsme_scan.sv
rtl/two_set_membership_engine_unit.sv
tb/testbench.sv
